// ===== src/sequence_argument_decoder_defines.svh =====
// Assertion macros for the sequence argument decoder.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SEQUENCE_ARGUMENT_DECODER_DEFINES_SVH
`define SEQUENCE_ARGUMENT_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SAD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SAD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sad_pkg.sv =====
package sad_pkg;

	// Variable store geometry
	localparam int VAR_COUNT = 32;
	localparam int VAR_AW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
	localparam logic [8:0] VAR_COUNT_W = 9'(VAR_COUNT);

	// Random generator constants
	localparam logic [31:0] LCG_MUL = 32'd1664525;
	localparam logic [31:0] LCG_ADD = 32'd1013904223;
	localparam logic [31:0] LCG_SEED = 32'h12345678;

	// Commands
	localparam logic CMD_FEED = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Value kinds
	localparam logic [2:0] KIND_U8 = 3'd0;
	localparam logic [2:0] KIND_U16 = 3'd1;
	localparam logic [2:0] KIND_VLQ = 3'd2;
	localparam logic [2:0] KIND_VAR = 3'd3;
	localparam logic [2:0] KIND_RAND = 3'd4;

	// Variable store access
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic [VAR_AW-1:0] addr;
		logic [31:0] wdata;
	} mem_req_t;

	// Random unit request and response
	typedef struct packed {
		logic start;
		logic [15:0] lo;
		logic [31:0] span;
	} rng_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] value;
	} rng_rsp_t;

endpackage

// ===== src/sad_if.sv =====
// Argument byte / store write channel
interface sad_feed_if;
	logic valid;
	logic ready;
	logic command;
	logic [2:0] value_kind;
	logic [7:0] data_byte;
	logic [4:0] var_index;
	logic signed [31:0] var_value;

	modport source (output valid, command, value_kind, data_byte, var_index, var_value,
		input ready);
	modport sink (input valid, command, value_kind, data_byte, var_index, var_value,
		output ready);
endinterface

// Decoded argument channel
interface sad_arg_if;
	logic valid;
	logic ready;
	logic signed [31:0] value;
	logic index_error;

	modport source (output valid, value, index_error, input ready);
	modport sink (input valid, value, index_error, output ready);
endinterface

// ===== src/sad_var_mem.sv =====
module sad_var_mem (
	input  logic clk,
	input  logic arst_n,
	input  sad_pkg::mem_req_t req,
	output logic [31:0] rdata
);
	import sad_pkg::*;

	logic [31:0] mem [VAR_COUNT];
	logic [VAR_COUNT-1:0] valid_q;
	logic [31:0] rdata_q;
	logic rvalid_q;

	// Write and read the storage array
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	// Track written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_q <= valid_q[req.addr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// ===== src/sad_rng.sv =====
module sad_rng (
	input  logic clk,
	input  logic arst_n,
	input  sad_pkg::rng_req_t req,
	output sad_pkg::rng_rsp_t rsp
);
	import sad_pkg::*;

	typedef enum logic [2:0] {P_IDLE, P_STEP, P_ADD, P_SCALE, P_DONE} phase_t;

	phase_t phase_q;
	logic [31:0] lcg_q;
	logic [31:0] prod_q;
	logic [31:0] span_q;
	logic [15:0] lo_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] mul_p;

	// Share one multiplier between generator step and scaling
	assign mul_a = (phase_q == P_STEP) ? lcg_q : {16'b0, lcg_q[31:16]};
	assign mul_b = (phase_q == P_STEP) ? LCG_MUL : span_q;
	assign mul_p = 32'(mul_a * mul_b);

	// Sequence step, add, scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			lcg_q <= LCG_SEED;
			prod_q <= '0;
			span_q <= '0;
			lo_q <= '0;
		end else begin
			unique case (phase_q)
				P_IDLE: begin
					if (req.start) begin
						span_q <= req.span;
						lo_q <= req.lo;
						phase_q <= P_STEP;
					end
				end
				P_STEP: begin
					prod_q <= mul_p;
					phase_q <= P_ADD;
				end
				P_ADD: begin
					lcg_q <= prod_q + LCG_ADD;
					phase_q <= P_SCALE;
				end
				P_SCALE: begin
					prod_q <= mul_p;
					phase_q <= P_DONE;
				end
				P_DONE: begin
					phase_q <= P_IDLE;
				end
				default: begin
					phase_q <= P_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = (phase_q == P_DONE);
	assign rsp.value = {{16{prod_q[31]}}, prod_q[31:16]} + {{16{lo_q[15]}}, lo_q};

endmodule

// ===== src/sequence_argument_decoder.sv =====
// Sequence argument decoder.
// The feed channel carries one word per byte of the argument stream
// (command feed) or one write into the variable store (command write).
// The value kind is taken from the first byte of each value and held until
// the value completes; the arg channel then delivers one word holding the
// decoded value and the index error flag. Store writes give no word.
// Throughput: one feed word per cycle while the block is idle. A u8, u16,
// variable-length or unknown-kind byte finishes in the accepting cycle; the
// word is registered at the output, or parked while it is full. A variable
// read waits for the synchronous store read. A random value passes the
// generator's step, add, scale and done phases; its single shared
// multiplier does the step and scaling. Feed is not taken while a read or
// random value is in progress. The output register lets a new word be
// accepted while a result waits; if a second result finishes before the
// first is taken, it is parked and feed stalls until the arg side takes it.
// Reset clears the decoder state, seeds the generator with 0x12345678 and
// marks every store entry as zero; no clearing pass is needed.
`include "sequence_argument_decoder_defines.svh"

module sequence_argument_decoder (
	input  logic clk,
	input  logic arst_n,
	sad_feed_if.sink feed,
	sad_arg_if.source arg
);
	import sad_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_READ, S_RAND, S_PUSH} state_t;

	state_t state_q;
	logic in_value_q;
	logic [2:0] kind_q;
	logic [1:0] seen_q;
	logic [31:0] acc_q;
	logic [15:0] lo_q;
	logic [31:0] res_q;
	logic res_err_q;
	logic arg_valid_q;
	logic [31:0] arg_value_q;
	logic arg_err_q;

	logic feed_fire;
	logic feed_byte;
	logic [2:0] kind_c;
	logic [1:0] seen_c;
	logic [31:0] acc_c;
	logic [7:0] byte_c;
	logic [31:0] vlq_c;
	logic [15:0] hi_c;
	logic idx_ok;
	logic wr_ok;
	logic out_free;
	logic fin_valid;
	logic [31:0] fin_value;
	logic fin_err;
	mem_req_t mem_req;
	logic [31:0] mem_rdata;
	rng_req_t rng_req;
	rng_rsp_t rng_rsp;

	sad_var_mem u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.req(mem_req),
		.rdata(mem_rdata)
	);

	sad_rng u_rng (
		.clk(clk),
		.arst_n(arst_n),
		.req(rng_req),
		.rsp(rng_rsp)
	);

	// Handshake and per-byte decode terms
	assign feed.ready = (state_q == S_IDLE);
	assign feed_fire = feed.valid && feed.ready;
	assign feed_byte = feed_fire && (feed.command == CMD_FEED);
	assign kind_c = in_value_q ? kind_q : feed.value_kind;
	assign seen_c = in_value_q ? seen_q : 2'd0;
	assign acc_c = in_value_q ? acc_q : '0;
	assign byte_c = feed.data_byte;
	assign vlq_c = {acc_c[24:0], byte_c[6:0]};
	assign hi_c = {byte_c, acc_c[7:0]};
	assign idx_ok = {1'b0, byte_c} < VAR_COUNT_W;
	assign wr_ok = {4'b0, feed.var_index} < VAR_COUNT_W;
	assign out_free = !arg_valid_q || arg.ready;

	// Store access
	always_comb begin
		mem_req.wr_en = feed_fire && (feed.command == CMD_WRITE) && wr_ok;
		mem_req.rd_en = feed_byte && (kind_c == KIND_VAR) && idx_ok;
		mem_req.addr = (feed.command == CMD_WRITE) ? VAR_AW'(feed.var_index)
			: VAR_AW'(byte_c);
		mem_req.wdata = feed.var_value;
	end

	// Random unit start on the last bound byte
	always_comb begin
		rng_req.start = feed_byte && (kind_c == KIND_RAND) && (seen_c == 2'd3);
		rng_req.lo = lo_q;
		rng_req.span = {{16{hi_c[15]}}, hi_c} - {{16{lo_q[15]}}, lo_q} + 32'd1;
	end

	// Select the finishing result, if any, this cycle
	always_comb begin
		fin_valid = 1'b0;
		fin_value = '0;
		fin_err = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (feed_byte) begin
					case (kind_c)
						KIND_U8: begin
							fin_valid = 1'b1;
							fin_value = {24'b0, byte_c};
						end
						KIND_U16: begin
							fin_valid = (seen_c != 2'd0);
							fin_value = {16'b0, hi_c};
						end
						KIND_VLQ: begin
							fin_valid = !byte_c[7];
							fin_value = vlq_c;
						end
						KIND_VAR: begin
							fin_valid = !idx_ok;
							fin_err = !idx_ok;
						end
						KIND_RAND: begin
							fin_valid = 1'b0;
						end
						default: begin
							fin_valid = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				fin_valid = 1'b1;
				fin_value = mem_rdata;
			end
			S_RAND: begin
				fin_valid = rng_rsp.done;
				fin_value = rng_rsp.value;
			end
			S_PUSH: begin
				fin_valid = 1'b1;
				fin_value = res_q;
				fin_err = res_err_q;
			end
			default: begin
				fin_valid = 1'b0;
			end
		endcase
	end

	// Decoder state, parking register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			in_value_q <= 1'b0;
			kind_q <= '0;
			seen_q <= '0;
			acc_q <= '0;
			lo_q <= '0;
			res_q <= '0;
			res_err_q <= 1'b0;
			arg_valid_q <= 1'b0;
			arg_value_q <= '0;
			arg_err_q <= 1'b0;
		end else begin
			// drop the word once taken
			if (arg_valid_q && arg.ready) begin
				arg_valid_q <= 1'b0;
			end
			// advance the value in progress
			if (feed_byte) begin
				kind_q <= kind_c;
				in_value_q <= 1'b0;
				seen_q <= 2'd0;
				case (kind_c)
					KIND_U16: begin
						if (seen_c == 2'd0) begin
							acc_q <= {24'b0, byte_c};
							seen_q <= 2'd1;
							in_value_q <= 1'b1;
						end
					end
					KIND_VLQ: begin
						acc_q <= vlq_c;
						in_value_q <= byte_c[7];
					end
					KIND_VAR: begin
						if (idx_ok) begin
							state_q <= S_READ;
						end
					end
					KIND_RAND: begin
						if (seen_c == 2'd3) begin
							state_q <= S_RAND;
						end else begin
							in_value_q <= 1'b1;
							seen_q <= seen_c + 2'd1;
							if (seen_c == 2'd1) begin
								lo_q <= hi_c;
							end else begin
								acc_q <= {24'b0, byte_c};
							end
						end
					end
					default: begin
						in_value_q <= 1'b0;
					end
				endcase
			end
			// hand the result to the output or park it
			if (fin_valid) begin
				if (out_free) begin
					arg_valid_q <= 1'b1;
					arg_value_q <= fin_value;
					arg_err_q <= fin_err;
					state_q <= S_IDLE;
				end else begin
					res_q <= fin_value;
					res_err_q <= fin_err;
					state_q <= S_PUSH;
				end
			end
		end
	end

	assign arg.valid = arg_valid_q;
	assign arg.value = arg_value_q;
	assign arg.index_error = arg_err_q;

	`SAD_ASSERT_IMP(a_push_full, state_q == S_PUSH, arg_valid_q, "parked result without full output")
	`SAD_ASSERT_IMP(a_err_zero, arg_valid_q && arg_err_q, arg_value_q == '0, "index error with nonzero value")
	`SAD_ASSERT_NXT(a_read_one, state_q == S_READ, state_q == S_IDLE || state_q == S_PUSH, "store read overran")
	`SAD_ASSERT_IMP(a_write_quiet, feed_fire && feed.command == CMD_WRITE, !fin_valid, "store write gave a result")

endmodule
